// ===== rtl/sensor_word_frame_decoder_unit_defines.svh =====
// assertion macros shared by the sensor word frame decoder rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SENSOR_WORD_FRAME_DECODER_UNIT_DEFINES_SVH
`define SENSOR_WORD_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define SWFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swfd_pkg.sv =====
// shared types, constants and the crc-8 step for the sensor word frame decoder
// no dependencies
`timescale 1ns / 1ps

package swfd_pkg;

  localparam int unsigned LONG_FRAME_WORDS = 8;
  localparam int unsigned GAS_FRAME_WORDS  = 3;
  localparam int unsigned WORDS_W          = 4;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [7:0]  CRC_POLY = 8'h31;

  localparam logic [15:0] CO2_LOWER_RESET = 16'd250;
  localparam logic [15:0] CO2_UPPER_RESET = 16'd10000;

  // scale factors, values in hundredths
  localparam logic [14:0] MUL_CO2  = 15'd100;
  localparam logic [14:0] MUL_TEMP = 15'd17500;
  localparam logic [14:0] MUL_HUM  = 15'd10000;
  localparam logic [14:0] MUL_PM   = 15'd10;
  localparam logic [14:0] MUL_UNIT = 15'd1;
  localparam logic [31:0] TEMP_OFFSET = 32'd294907500;  // 4500 * 65535
  localparam logic [16:0] RATIO_DIV   = 17'd65535;

  localparam logic [2:0] GAS_CO2_IDX   = 3'd0;
  localparam logic [2:0] GAS_TEMP_IDX  = 3'd1;
  localparam logic [2:0] LONG_HUM_IDX  = 3'd4;
  localparam logic [2:0] LONG_TEMP_IDX = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CRC_ERR   = 2'd1,
    STATUS_CO2_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REG_CO2_LOWER = 1'b0,
    REG_CO2_UPPER = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    LAYOUT_GAS = 1'b0,
    LAYOUT_PM  = 1'b1
  } layout_e;

  typedef enum logic [1:0] {
    PHASE_HIGH  = 2'd0,
    PHASE_LOW   = 2'd1,
    PHASE_CHECK = 2'd2
  } byte_phase_e;

  typedef enum logic [1:0] {
    SCALE_DIRECT       = 2'd0,
    SCALE_RATIO        = 2'd1,
    SCALE_SIGNED_RATIO = 2'd2
  } scale_mode_e;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [15:0] raw_word;
    layout_e     layout;
    status_e     status;
    logic        frame_failed;
    logic        last;
  } word_item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/sensor_word_frame_decoder_unit.sv =====
// Sensor word frame decoder top level.
// Input stream: one response byte per transaction; tuser carries the frame
//   start flag and the frame layout (0 three-word gas frame, 1 eight-word
//   particulate frame), sampled on the frame start byte.
// Every third byte of a frame ends a word: its crc-8 (poly 0x31, init 0xff)
//   is checked and one result transaction goes out with the word index, raw
//   word, value in hundredths and status; tlast marks the final word.
// The first crc error ends the frame; its remaining bytes give no result.
// Config port: register 0 co2 lower limit, register 1 co2 upper limit, to be
//   written by the user only while the block is idle; the block does not enforce it.
// Throughput: one byte per cycle while s_axis_tready is high. Path: after the byte
//   that completes its word, a result passes a queue slot, 3 scaling stages and the
//   output register.
// Reset clears the frame state; bytes are ignored until a frame start.
// When the receiver stalls, results pile up in the scaling pipeline and a
//   two-word queue; s_axis_tready drops once that queue is full.
// depends on swfd_pkg, swfd_front, swfd_queue and swfd_back
`timescale 1ns / 1ps

module sensor_word_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [0] frame_start, [1] sensor_kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [2:0] word_index, [18:3] raw_word,
                                      // [42:19] value_hundredths, [47:43] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] frame_failed
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  logic                 byte_accept;
  logic                 word_valid, queue_full, queue_valid, queue_pop;
  swfd_pkg::word_item_t front_word, queue_word, out_word;
  logic signed [23:0]   out_value;

  assign s_axis_tready = !queue_full;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  swfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_accept),
    .rx_byte_i     (s_axis_tdata),
    .frame_start_i (s_axis_tuser[0]),
    .sensor_kind_i (s_axis_tuser[1]),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .word_valid_o  (word_valid),
    .word_o        (front_word)
  );

  swfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (word_valid),
    .item_i  (front_word),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_word)
  );

  swfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_word),
    .item_pop_o   (queue_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_item_o   (out_word),
    .out_value_o  (out_value)
  );

  assign m_axis_tdata = {5'd0, out_value, out_word.raw_word, out_word.word_index};
  assign m_axis_tuser = {out_word.frame_failed, out_word.status};
  assign m_axis_tlast = out_word.last;

endmodule

// ===== rtl/swfd_front.sv =====
// front end: byte assembly, crc check, frame tracking and co2 limit check
// depends on swfd_pkg
`timescale 1ns / 1ps

module swfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic               sensor_kind_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               word_valid_o,
  output swfd_pkg::word_item_t word_o
);

  swfd_pkg::byte_phase_e phase_q, phase_d, phase_s;
  logic [2:0]            wc_q, wc_d, wc_s;
  logic [7:0]            crc_q, crc_d, crc_s;
  logic [7:0]            hi_q, hi_d, lo_q, lo_d;
  swfd_pkg::layout_e     layout_q, layout_d, layout_s;
  logic                  err_q, err_d, err_s;
  logic                  drop_q, drop_d, drop_s;
  logic [15:0]           co2_lo_q, co2_hi_q;

  logic [15:0]                 raw;
  logic                        crc_fail, co2_bad, at_end, is_last, err_new;
  logic [swfd_pkg::WORDS_W-1:0] words, wc_inc;

  // state as seen by this byte once a frame start is applied
  always_comb begin
    layout_s = layout_q;
    phase_s  = phase_q;
    wc_s     = wc_q;
    crc_s    = crc_q;
    err_s    = err_q;
    drop_s   = drop_q;
    if (frame_start_i) begin
      layout_s = swfd_pkg::layout_e'(sensor_kind_i);
      phase_s  = swfd_pkg::PHASE_HIGH;
      wc_s     = '0;
      crc_s    = swfd_pkg::CRC_INIT;
      err_s    = 1'b0;
      drop_s   = 1'b0;
    end
  end

  assign raw      = {hi_q, lo_q};
  assign crc_fail = (crc_s != rx_byte_i);
  assign co2_bad  = (layout_s == swfd_pkg::LAYOUT_GAS) && (wc_s == swfd_pkg::GAS_CO2_IDX) &&
                    ((raw == 16'd0) || (raw < co2_lo_q) || (raw > co2_hi_q));
  assign words    = (layout_s == swfd_pkg::LAYOUT_PM) ?
                    swfd_pkg::WORDS_W'(swfd_pkg::LONG_FRAME_WORDS) :
                    swfd_pkg::WORDS_W'(swfd_pkg::GAS_FRAME_WORDS);
  assign wc_inc   = {1'b0, wc_s} + 4'd1;
  assign at_end   = (wc_inc >= words);
  assign is_last  = crc_fail || at_end;
  assign err_new  = err_s || crc_fail || co2_bad;

  always_comb begin
    word_o.word_index   = wc_s;
    word_o.raw_word     = raw;
    word_o.layout       = layout_s;
    word_o.last         = is_last;
    word_o.frame_failed = is_last && err_new;
    if (crc_fail) begin
      word_o.status = swfd_pkg::STATUS_CRC_ERR;
    end else if (co2_bad) begin
      word_o.status = swfd_pkg::STATUS_CO2_RANGE;
    end else begin
      word_o.status = swfd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    wc_d         = wc_q;
    crc_d        = crc_q;
    hi_d         = hi_q;
    lo_d         = lo_q;
    layout_d     = layout_q;
    err_d        = err_q;
    drop_d       = drop_q;
    word_valid_o = 1'b0;
    if (byte_valid_i) begin
      phase_d  = phase_s;
      wc_d     = wc_s;
      crc_d    = crc_s;
      layout_d = layout_s;
      err_d    = err_s;
      drop_d   = drop_s;
      if (!drop_s) begin
        case (phase_s)
          swfd_pkg::PHASE_HIGH: begin
            hi_d    = rx_byte_i;
            crc_d   = swfd_pkg::crc8_step(crc_s, rx_byte_i);
            phase_d = swfd_pkg::PHASE_LOW;
          end
          swfd_pkg::PHASE_LOW: begin
            lo_d    = rx_byte_i;
            crc_d   = swfd_pkg::crc8_step(crc_s, rx_byte_i);
            phase_d = swfd_pkg::PHASE_CHECK;
          end
          swfd_pkg::PHASE_CHECK: begin
            word_valid_o = 1'b1;
            phase_d      = swfd_pkg::PHASE_HIGH;
            crc_d        = swfd_pkg::CRC_INIT;
            wc_d         = wc_s + 3'd1;
            err_d        = err_new;
            drop_d       = is_last;
          end
          default: begin
            phase_d = swfd_pkg::PHASE_HIGH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= swfd_pkg::PHASE_HIGH;
      wc_q     <= '0;
      crc_q    <= swfd_pkg::CRC_INIT;
      hi_q     <= '0;
      lo_q     <= '0;
      layout_q <= swfd_pkg::LAYOUT_GAS;
      err_q    <= 1'b0;
      drop_q   <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      wc_q     <= wc_d;
      crc_q    <= crc_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      layout_q <= layout_d;
      err_q    <= err_d;
      drop_q   <= drop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co2_lo_q <= swfd_pkg::CO2_LOWER_RESET;
      co2_hi_q <= swfd_pkg::CO2_UPPER_RESET;
    end else if (cfg_we_i) begin
      case (swfd_pkg::cfg_reg_e'(cfg_addr_i))
        swfd_pkg::REG_CO2_LOWER: co2_lo_q <= cfg_wdata_i;
        swfd_pkg::REG_CO2_UPPER: co2_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/swfd_queue.sv =====
// short word queue between the front end and the scaling back end
// depends on swfd_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "sensor_word_frame_decoder_unit_defines.svh"

module swfd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  swfd_pkg::word_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output swfd_pkg::word_item_t item_o
);

  localparam int unsigned PtrW = (swfd_pkg::QUEUE_DEPTH > 1) ? $clog2(swfd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(swfd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(swfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(swfd_pkg::QUEUE_DEPTH);

  swfd_pkg::word_item_t slot_q [swfd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `SWFD_ASSERT_NOW(a_no_push_full, push_i, !full_o, "word pushed into a full queue")
  `SWFD_ASSERT_NOW(a_no_pop_empty, pop_i, valid_o, "word popped from an empty queue")
  `SWFD_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1,
                    "queue count did not follow a push")

endmodule

// ===== rtl/swfd_back.sv =====
// back end: scales each word to hundredths and holds the result transaction
// depends on swfd_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "sensor_word_frame_decoder_unit_defines.svh"

module swfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  swfd_pkg::word_item_t item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swfd_pkg::word_item_t out_item_o,
  output logic signed [23:0]   out_value_o
);

  logic en;

  // stage 1: constant multiply
  swfd_pkg::scale_mode_e mode_c;
  logic [14:0]           mul_c;
  logic [15:0]           operand_c;
  logic                  s1_vld_q;
  swfd_pkg::word_item_t  s1_item_q;
  swfd_pkg::scale_mode_e s1_mode_q;
  logic [30:0]           s1_prod_q;

  // stage 2: offset and magnitude
  logic [31:0]           diff_c;
  logic                  neg_c;
  logic [30:0]           mag_c;
  logic                  s2_vld_q;
  swfd_pkg::word_item_t  s2_item_q;
  logic                  s2_ratio_q, s2_neg_q;
  logic [30:0]           s2_mag_q;

  // stage 3: quotient estimate for division by 65535
  logic [31:0]           sum_c, rem_c;
  logic [15:0]           qest_c;
  logic                  s3_vld_q;
  swfd_pkg::word_item_t  s3_item_q;
  logic                  s3_ratio_q, s3_neg_q;
  logic [23:0]           s3_direct_q;
  logic [15:0]           s3_qest_q;
  logic [16:0]           s3_rem_q;

  // output register
  logic [16:0]           quot_c;
  logic [23:0]           res_mag_c;
  logic signed [23:0]    res_c;
  logic                  out_vld_q;
  swfd_pkg::word_item_t  out_item_q;
  logic signed [23:0]    out_val_q;

  assign en         = !out_vld_q || out_ready_i;
  assign item_pop_o = en && item_valid_i;

  always_comb begin
    mode_c    = swfd_pkg::SCALE_DIRECT;
    mul_c     = swfd_pkg::MUL_PM;
    operand_c = item_i.raw_word;
    case (item_i.layout)
      swfd_pkg::LAYOUT_GAS: begin
        if (item_i.word_index == swfd_pkg::GAS_CO2_IDX) begin
          mul_c = swfd_pkg::MUL_CO2;
        end else if (item_i.word_index == swfd_pkg::GAS_TEMP_IDX) begin
          mode_c = swfd_pkg::SCALE_SIGNED_RATIO;
          mul_c  = swfd_pkg::MUL_TEMP;
        end else begin
          mode_c = swfd_pkg::SCALE_RATIO;
          mul_c  = swfd_pkg::MUL_HUM;
        end
      end
      swfd_pkg::LAYOUT_PM: begin
        if (item_i.word_index == swfd_pkg::LONG_HUM_IDX) begin
          mul_c = swfd_pkg::MUL_UNIT;
        end else if (item_i.word_index == swfd_pkg::LONG_TEMP_IDX) begin
          mul_c     = swfd_pkg::MUL_UNIT;
          operand_c = {1'b0, item_i.raw_word[15:1]};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    diff_c = {1'b0, s1_prod_q} - swfd_pkg::TEMP_OFFSET;
    neg_c  = 1'b0;
    mag_c  = s1_prod_q;
    if (s1_mode_q == swfd_pkg::SCALE_SIGNED_RATIO) begin
      neg_c = diff_c[31];
      mag_c = diff_c[31] ? 31'(-diff_c) : diff_c[30:0];
    end
  end

  // estimate never exceeds the quotient and falls short by at most one
  assign sum_c  = {1'b0, s2_mag_q} + {17'd0, s2_mag_q[30:16]};
  assign qest_c = sum_c[31:16];
  assign rem_c  = {1'b0, s2_mag_q} - ({qest_c, 16'd0} - {16'd0, qest_c});

  always_comb begin
    quot_c    = {1'b0, s3_qest_q} + ((s3_rem_q >= swfd_pkg::RATIO_DIV) ? 17'd1 : 17'd0);
    res_mag_c = s3_ratio_q ? {7'd0, quot_c} : s3_direct_q;
    res_c     = s3_neg_q ? -$signed(res_mag_c) : $signed(res_mag_c);
    if (s3_item_q.status == swfd_pkg::STATUS_CRC_ERR) begin
      res_c = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= item_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q   <= item_i;
      s1_mode_q   <= mode_c;
      s1_prod_q   <= 31'(operand_c * mul_c);
      s2_item_q   <= s1_item_q;
      s2_ratio_q  <= (s1_mode_q != swfd_pkg::SCALE_DIRECT);
      s2_neg_q    <= neg_c;
      s2_mag_q    <= mag_c;
      s3_item_q   <= s2_item_q;
      s3_ratio_q  <= s2_ratio_q;
      s3_neg_q    <= s2_neg_q;
      s3_direct_q <= s2_mag_q[23:0];
      s3_qest_q   <= qest_c;
      s3_rem_q    <= rem_c[16:0];
      out_item_q  <= s3_item_q;
      out_val_q   <= res_c;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;
  assign out_value_o = out_val_q;

  `SWFD_ASSERT_NOW(a_crc_err_zero, out_vld_q && (out_item_q.status == swfd_pkg::STATUS_CRC_ERR),
                   (out_val_q == '0) && out_item_q.last, "crc error result not zero and final")
  `SWFD_ASSERT_NOW(a_failed_on_last, out_vld_q && out_item_q.frame_failed, out_item_q.last,
                   "frame failure flagged on a result that is not final")
  `SWFD_ASSERT_NEXT(a_pop_flows, item_pop_o, s1_vld_q, "popped word lost before stage one")

endmodule

// ===== bench/sensor_word_frame_decoder_unit_tb.sv =====
// Self-checking bench for sensor_word_frame_decoder_unit: byte stream in, decoded words out.
// A built-in decoder model predicts the words of random frames, after a directed table with typed-in results.
// Depends on swfd_pkg and the decoder rtl only.
`timescale 1ns / 1ps

module sensor_word_frame_decoder_unit_tb;
  import swfd_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_ITEMS  = 290;
  localparam int N_DIR        = 30;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] raw;
    logic [23:0] val;
    status_e     st;
    logic        failed;
    logic        is_last;
  } word_result_t;

  typedef enum logic [1:0] {
    BYTE_PLAIN    = 2'd0,
    BYTE_CRC_GOOD = 2'd1,
    BYTE_CRC_BAD  = 2'd2
  } byte_src_e;

  typedef struct packed {
    logic [7:0]   data;
    logic         start;
    logic         kind;
    byte_src_e    src;
    logic         has_res;
    word_result_t res;
  } dir_row_t;

  // directed frames; every expected result is typed in
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // ignored before any frame start
    '{8'h5A, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b1, BYTE_PLAIN, 1'b0, '0},
    // gas frame: co2 zero, lowest temperature, full humidity
    '{8'h00, 1'b1, LAYOUT_GAS, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_GOOD, 1'b1,
      '{3'd0, 16'h0000, 24'd0, STATUS_CO2_RANGE, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_GOOD, 1'b1,
      '{3'd1, 16'h0000, -24'sd4500, STATUS_OK, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, BYTE_CRC_GOOD, 1'b1,
      '{3'd2, 16'hFFFF, 24'd10000, STATUS_OK, 1'b1, 1'b1}},
    // particulate frame: top pm value, then a crc error ends it
    '{8'hFF, 1'b1, LAYOUT_PM, BYTE_PLAIN, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_GOOD, 1'b1,
      '{3'd0, 16'hFFFF, 24'd655350, STATUS_OK, 1'b0, 1'b0}},
    '{8'h12, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h34, 1'b0, 1'b1, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_BAD, 1'b1,
      '{3'd1, 16'h1234, 24'd0, STATUS_CRC_ERR, 1'b1, 1'b1}},
    '{8'h77, 1'b0, 1'b1, BYTE_PLAIN, 1'b0, '0},
    // gas frame: co2 right at the lower limit, top temperature
    '{8'h00, 1'b1, LAYOUT_GAS, BYTE_PLAIN, 1'b0, '0},
    '{8'hFA, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_GOOD, 1'b1,
      '{3'd0, 16'h00FA, 24'd25000, STATUS_OK, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_GOOD, 1'b1,
      '{3'd1, 16'hFFFF, 24'd13000, STATUS_OK, 1'b0, 1'b0}},
    // restart in the middle of a word, new frame fails its first crc
    '{8'h40, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'hFF, 1'b1, LAYOUT_GAS, BYTE_PLAIN, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, BYTE_CRC_BAD, 1'b1,
      '{3'd0, 16'hFFFF, 24'd0, STATUS_CRC_ERR, 1'b1, 1'b1}},
    '{8'h5A, 1'b0, 1'b0, BYTE_PLAIN, 1'b0, '0},
    '{8'hC3, 1'b0, 1'b1, BYTE_PLAIN, 1'b0, '0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_wdata_i   = '0;

  sensor_word_frame_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] frame_start, [1] sensor_kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [2:0] word_index, [18:3] raw_word, [42:19] value
    .m_axis_tuser  (m_axis_tuser),   // [1:0] status, [2] frame_failed
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // decoder model state and its copy of the limits
  byte_phase_e  pr_phase  = PHASE_HIGH;
  logic [2:0]   pr_count  = '0;
  logic [7:0]   pr_crc    = 8'hFF;
  logic [7:0]   pr_hi     = '0;
  logic [7:0]   pr_lo     = '0;
  layout_e      pr_layout = LAYOUT_GAS;
  logic         pr_err    = 1'b0;
  logic         pr_idle   = 1'b1;
  logic [15:0]  lim_lo    = 16'd250;
  logic [15:0]  lim_hi    = 16'd10000;

  word_result_t words_due [$];
  int           err_count     = 0;
  int           decoded_items = 0;
  int           cycle_count   = 0;
  int           tx_gap_max    = 18;
  int           rx_stall_max  = 18;
  int           rx_hold       = 0;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
    end
    return c;
  endfunction

  function automatic longint scaled_hundredths(input layout_e lay, input logic [2:0] idx,
                                               input logic [15:0] raw);
    longint r;
    r = longint'(raw);
    if (lay == LAYOUT_GAS) begin
      if (idx == GAS_CO2_IDX) return r * 100;
      // integer division truncates toward zero, as required for negative temperatures
      if (idx == GAS_TEMP_IDX) return (r * 17500 - 64'sd4500 * 65535) / 65535;
      return (r * 10000) / 65535;
    end
    if (idx == LONG_HUM_IDX) return r;
    if (idx == LONG_TEMP_IDX) return r / 2;
    return r * 10;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st, input logic kd,
                             output bit got, output word_result_t r);
    int          nwords;
    logic [15:0] raw;
    got = 0;
    r   = '0;
    if (st) begin
      pr_layout = layout_e'(kd);
      pr_phase  = PHASE_HIGH;
      pr_count  = '0;
      pr_crc    = 8'hFF;
      pr_err    = 1'b0;
      pr_idle   = 1'b0;
    end
    if (pr_idle) return;
    decoded_items++;
    case (pr_phase)
      PHASE_HIGH: begin
        pr_hi    = b;
        pr_crc   = crc_byte(pr_crc, b);
        pr_phase = PHASE_LOW;
      end
      PHASE_LOW: begin
        pr_lo    = b;
        pr_crc   = crc_byte(pr_crc, b);
        pr_phase = PHASE_CHECK;
      end
      default: begin
        nwords = (pr_layout == LAYOUT_PM) ? LONG_FRAME_WORDS : GAS_FRAME_WORDS;
        raw    = {pr_hi, pr_lo};
        r.idx  = pr_count;
        r.raw  = raw;
        if (pr_crc != b) begin
          r.st      = STATUS_CRC_ERR;
          r.val     = '0;
          r.is_last = 1'b1;
          pr_err    = 1'b1;
        end else begin
          r.st  = STATUS_OK;
          r.val = 24'(scaled_hundredths(pr_layout, pr_count, raw));
          if (pr_layout == LAYOUT_GAS && pr_count == GAS_CO2_IDX &&
              (raw == 0 || raw < lim_lo || raw > lim_hi)) begin
            r.st   = STATUS_CO2_RANGE;
            pr_err = 1'b1;
          end
          r.is_last = (int'(pr_count) + 1 >= nwords);
        end
        r.failed = r.is_last && pr_err;
        pr_phase = PHASE_HIGH;
        pr_crc   = 8'hFF;
        pr_count = pr_count + 3'd1;
        if (r.is_last) pr_idle = 1'b1;
        got = 1;
      end
    endcase
  endtask

  // offer one byte, wait for the transaction, then record what it should produce
  task automatic send_byte(input logic [7:0] b, input logic st, input logic kd,
                           input bit typed, input bit typed_has, input word_result_t typed_res);
    int           gap;
    bit           got;
    word_result_t res;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {kd, st};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, st, kd, got, res);
    if (typed) begin
      if (typed_has) words_due.push_back(typed_res);
    end else if (got) begin
      words_due.push_back(res);
    end
  endtask

  task automatic send_rand_byte(input logic [7:0] b, input logic st, input logic kd);
    send_byte(b, st, kd, 1'b0, 1'b0, '0);
  endtask

  // let every outstanding word come back, then give in-flight bytes time to settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [15:0] lo, input logic [15:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_CO2_LOWER;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_addr_i  <= REG_CO2_UPPER;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_lo = lo;
    lim_hi = hi;
  endtask

  function automatic logic [15:0] pick_raw(input layout_e lay, input int w);
    if (lay == LAYOUT_GAS && w == 0) begin
      // aim at the co2 window edges
      case ($urandom_range(0, 9))
        0:       return 16'h0000;
        1:       return lim_lo - 16'd1;
        2:       return lim_lo;
        3:       return lim_lo + 16'd1;
        4:       return lim_hi - 16'd1;
        5:       return lim_hi;
        6:       return lim_hi + 16'd1;
        7:       return 16'hFFFF;
        default: return 16'($urandom);
      endcase
    end
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    layout_e     lay;
    int          nwords;
    int          cut;
    int          bad_word;
    int          pos;
    logic [15:0] raw;
    logic [7:0]  b;
    // now and then pure noise with random start flags
    if ($urandom_range(0, 14) == 0) begin
      repeat (4) send_rand_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
      return;
    end
    lay      = layout_e'($urandom_range(0, 1));
    nwords   = (lay == LAYOUT_PM) ? LONG_FRAME_WORDS : GAS_FRAME_WORDS;
    bad_word = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nwords - 1) : -1;
    cut      = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 3 * nwords - 1) : -1;
    for (int w = 0; w < nwords; w++) begin
      raw = pick_raw(lay, w);
      for (int j = 0; j < 3; j++) begin
        pos = 3 * w + j;
        if (pos == cut) return;  // next frame start abandons this one
        if (j == 0) b = raw[15:8];
        else if (j == 1) b = raw[7:0];
        else if (w == bad_word) b = pr_crc ^ 8'($urandom_range(1, 255));
        else b = pr_crc;
        send_rand_byte(b, pos == 0, (pos == 0) ? logic'(lay) : 1'($urandom));
      end
      if (w == bad_word) break;
    end
    // trailing bytes after the frame has ended are ignored
    repeat ($urandom_range(0, 2)) send_rand_byte(8'($urandom), 1'b0, 1'($urandom));
  endtask

  function automatic int pick_idle_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int           gap;
    word_result_t want;
    logic [23:0]  got_val;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, rx_stall_max);
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (words_due.size() == 0) begin
        $error("unexpected word transaction: raw %h", m_axis_tdata[18:3]);
        err_count++;
      end else begin
        want    = words_due.pop_front();
        got_val = m_axis_tdata[42:19];
        if (m_axis_tdata[2:0] != want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, m_axis_tdata[2:0]);
          err_count++;
        end
        if (m_axis_tdata[18:3] != want.raw) begin
          $error("raw_word: expected %h, got %h", want.raw, m_axis_tdata[18:3]);
          err_count++;
        end
        if (got_val != want.val) begin
          $error("value_hundredths: expected %0d, got %0d",
                 $signed(want.val), $signed(got_val));
          err_count++;
        end
        if (m_axis_tuser[1:0] != want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tuser[1:0]);
          err_count++;
        end
        if (m_axis_tuser[2] != want.failed) begin
          $error("frame_failed: expected %0d, got %0d", want.failed, m_axis_tuser[2]);
          err_count++;
        end
        if (m_axis_tlast != want.is_last) begin
          $error("last: expected %0d, got %0d", want.is_last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL sensor_word_frame_decoder_unit");
      $finish;
    end
  end

  initial begin
    logic [7:0]  b;
    logic [15:0] lo;
    logic [15:0] hi;
    int          target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      case (DIR_ROWS[i].src)
        BYTE_CRC_GOOD: b = pr_crc;
        BYTE_CRC_BAD:  b = pr_crc ^ 8'h01;
        default:       b = DIR_ROWS[i].data;
      endcase
      send_byte(b, DIR_ROWS[i].start, DIR_ROWS[i].kind, 1'b1,
                DIR_ROWS[i].has_res, DIR_ROWS[i].res);
    end
    drain_results();

    // phase 0 runs on the reset limits, then wide open, crossed, ordered random, tight, unordered random
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lo = CO2_LOWER_RESET; hi = CO2_UPPER_RESET; end
        1: begin lo = 16'h0000; hi = 16'hFFFF; end
        2: begin lo = 16'hFFFF; hi = 16'h0000; end
        3: begin
          lo = 16'($urandom_range(0, 30000));
          hi = lo + 16'($urandom_range(0, 30000));
        end
        4: begin lo = 16'd1; hi = 16'd1; end
        default: begin lo = 16'($urandom); hi = 16'($urandom); end
      endcase
      if (p > 0) write_limits(lo, hi);
      tx_gap_max   = pick_idle_max();
      rx_stall_max = pick_idle_max();
      target       = decoded_items + PHASE_ITEMS;
      while (decoded_items < target) send_frame();
      drain_results();
    end

    // receiver holds off while bytes keep coming back to back
    write_limits(CO2_LOWER_RESET, CO2_UPPER_RESET);
    tx_gap_max   = 0;
    rx_stall_max = 18;
    rx_hold      = 400;
    target       = decoded_items + 150;
    while (decoded_items < target) send_frame();
    drain_results();

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS sensor_word_frame_decoder_unit");
    end else begin
      $display("FAIL sensor_word_frame_decoder_unit");
    end
    $finish;
  end

endmodule
